/* design/rssc_pkg.sv */
package rssc_pkg;

   // quotient bits of the plane parameter, one per divider stage
   localparam int DIV_STEPS = 16;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_SURFACE_KIND   = 3'd0,
      CSR_ANCHOR_POINT   = 3'd1,
      CSR_UNIT_NORMAL    = 3'd2,
      CSR_RADIUS_SQUARED = 3'd3,
      CSR_EDGE_ONE       = 3'd4,
      CSR_EDGE_TWO       = 3'd5,
      CSR_MIN_COSINE     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [15:0]        step_len;
   } req_word_type;

   typedef struct packed {
      logic               crosses;
      logic signed [15:0] entrance_cos;
   } rsp_word_type;

   // surface description seen by the pipeline, anchor and edge components already sign extended
   typedef struct packed {
      logic             kind;
      logic [2:0][15:0] anc;
      logic [2:0][15:0] nrm;
      logic [2:0][15:0] e1;
      logic [2:0][15:0] e2;
      logic [31:0]      rsq;
      logic [14:0]      min_cos;
      logic [32:0]      len1;
      logic [32:0]      len2;
   } cfg_type;

   // what travels alongside the divider
   typedef struct packed {
      logic             reject;
      logic [15:0]      ec;
      logic [2:0][15:0] dir;
      logic [2:0][16:0] diff;
      logic [15:0]      step_len;
   } side_type;

   // sign extend the low bits of a coordinate slot, sh = 16 - coordinate width
   function automatic logic [15:0] sext_coord(input logic [15:0] v, input logic [4:0] sh);
      logic signed [15:0] t;
      t = $signed(v << sh);
      return 16'(t >>> sh);
   endfunction

endpackage

/* design/ray_segment_surface_crossing_unit.sv */
// Photon step versus disc or rectangle crossing test.
// req channel: one word per photon step (position Q8.8, direction Q1.14,
// free path Q8.8), taken on a clock edge with req_valid high and req_stall
// low. rsp channel: one word per step, crosses plus the entrance cosine
// (zero when the step misses), in the order the steps came in.
// csr port: csr_write with csr_index and csr_data sets one surface register;
// write only while no step is in flight.
// Throughput is one step per cycle while rsp_stall does not hold the pipeline.
// From acceptance to rsp_valid a step passes the dot products and range tests,
// the one-bit-per-stage divider that forms the plane parameter, and then the
// hit point, squares or edge projections and the inside test.
// When rsp_valid is high and rsp_stall is asserted the whole pipeline holds
// and req_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and the surface registers (min_cosine to one LSB).
module ray_segment_surface_crossing_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rssc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rssc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write,
   input  logic [2:0]             csr_index,
   input  logic [47:0]            csr_data
);
   import rssc_pkg::*;

   localparam int CW_EFF = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
   localparam logic [4:0] CW_SHIFT = 5'(16 - CW_EFF);

   logic             kind_ff;
   logic [47:0]      anchor_ff;
   logic [47:0]      normal_ff;
   logic [31:0]      rsq_ff;
   logic [47:0]      edge1_ff;
   logic [47:0]      edge2_ff;
   logic [14:0]      min_cos_ff;
   logic [31:0]      esq1_ff [3];
   logic [31:0]      esq2_ff [3];
   logic [32:0]      len1_ff;
   logic [32:0]      len2_ff;

   cfg_type          cfg;
   req_word_type     req_ext;
   logic             en;

   logic             f_valid;
   logic [33:0]      f_rem;
   logic [1:0]       f_lo;
   logic [31:0]      f_c;
   side_type         f_side;
   logic             d_valid;
   logic [15:0]      d_q;
   side_type         d_side;

   // surface registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= 1'b0;
         anchor_ff  <= '0;
         normal_ff  <= '0;
         rsq_ff     <= '0;
         edge1_ff   <= '0;
         edge2_ff   <= '0;
         min_cos_ff <= 15'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SURFACE_KIND:   kind_ff    <= csr_data[0];
            CSR_ANCHOR_POINT:   anchor_ff  <= csr_data;
            CSR_UNIT_NORMAL:    normal_ff  <= csr_data;
            CSR_RADIUS_SQUARED: rsq_ff     <= csr_data[31:0];
            CSR_EDGE_ONE:       edge1_ff   <= csr_data;
            CSR_EDGE_TWO:       edge2_ff   <= csr_data;
            CSR_MIN_COSINE:     min_cos_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // sign-extended surface view
   always_comb begin
      cfg.kind    = kind_ff;
      cfg.rsq     = rsq_ff;
      cfg.min_cos = min_cos_ff;
      cfg.len1    = len1_ff;
      cfg.len2    = len2_ff;
      for (int i = 0; i < 3; i++) begin
         cfg.anc[i] = sext_coord(anchor_ff[16*i +: 16], CW_SHIFT);
         cfg.nrm[i] = normal_ff[16*i +: 16];
         cfg.e1[i]  = sext_coord(edge1_ff[16*i +: 16], CW_SHIFT);
         cfg.e2[i]  = sext_coord(edge2_ff[16*i +: 16], CW_SHIFT);
      end
   end

   // squared edge lengths, settled long before a step reaches the inside test
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         esq1_ff[i] <= 32'($signed(cfg.e1[i]) * $signed(cfg.e1[i]));
         esq2_ff[i] <= 32'($signed(cfg.e2[i]) * $signed(cfg.e2[i]));
      end
      len1_ff <= 33'(esq1_ff[0]) + 33'(esq1_ff[1]) + 33'(esq1_ff[2]);
      len2_ff <= 33'(esq2_ff[0]) + 33'(esq2_ff[1]) + 33'(esq2_ff[2]);
   end

   // position sign extension for narrow coordinates
   always_comb begin
      req_ext       = req_word;
      req_ext.pos_x = sext_coord(req_word.pos_x, CW_SHIFT);
      req_ext.pos_y = sext_coord(req_word.pos_y, CW_SHIFT);
      req_ext.pos_z = sext_coord(req_word.pos_z, CW_SHIFT);
   end

   // pipeline advances unless a finished word is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   rssc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_word   (req_ext),
      .cfg       (cfg),
      .out_valid (f_valid),
      .out_rem   (f_rem),
      .out_lo    (f_lo),
      .out_c     (f_c),
      .out_side  (f_side)
   );

   rssc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_rem    (f_rem),
      .in_lo     (f_lo),
      .in_c      (f_c),
      .in_side   (f_side),
      .out_valid (d_valid),
      .out_q     (d_q),
      .out_side  (d_side)
   );

   rssc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_t      (d_q),
      .in_side   (d_side),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

`ifndef NO_ASSERTIONS
   // a miss carries no cosine
   a_miss_zero_cos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.crosses |-> rsp_word.entrance_cos == 16'sd0)
      else $error("miss with nonzero entrance cosine");

   // a hit cosine is non-negative and saturated at one
   a_hit_cos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.crosses |->
         !rsp_word.entrance_cos[15] && rsp_word.entrance_cos <= 16'sd16384)
      else $error("entrance cosine out of range");

   // no word leaves the pipeline right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");
`endif

endmodule

/* design/rssc_front.sv */
module rssc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rssc_pkg::req_word_type in_word,
   input  rssc_pkg::cfg_type cfg,
   output logic              out_valid,
   output logic [33:0]       out_rem,
   output logic [1:0]        out_lo,
   output logic [31:0]       out_c,
   output rssc_pkg::side_type out_side
);
   import rssc_pkg::*;

   logic [15:0] pos [3];
   logic [15:0] dir [3];

   // stage 1: lane products
   logic               v1_ff;
   logic signed [31:0] dn_ff [3];
   logic signed [32:0] an_ff [3];
   logic [2:0][16:0]   diff1_ff;
   logic [2:0][15:0]   dir1_ff;
   logic [15:0]        f1_ff;

   // stage 2: dot product sums
   logic               v2_ff;
   logic signed [33:0] c28_ff;
   logic signed [34:0] n22_ff;
   logic [2:0][16:0]   diff2_ff;
   logic [2:0][15:0]   dir2_ff;
   logic [15:0]        f2_ff;

   // stage 3: range limit and cosine tests
   logic               v3_ff;
   logic               rej3_ff;
   logic [33:0]        lim3_ff;
   logic [34:0]        n3_ff;
   logic [31:0]        c3_ff;
   logic [15:0]        ec3_ff;
   logic [2:0][16:0]   diff3_ff;
   logic [2:0][15:0]   dir3_ff;
   logic [15:0]        f3_ff;

   logic [47:0]        fc;
   logic [32:0]        ec_sum;
   logic               rej3_in;
   logic [15:0]        ec3_in;
   logic               rej4_in;

   assign pos[0] = in_word.pos_x;
   assign pos[1] = in_word.pos_y;
   assign pos[2] = in_word.pos_z;
   assign dir[0] = in_word.dir_x;
   assign dir[1] = in_word.dir_y;
   assign dir[2] = in_word.dir_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dn_ff[i]    <= $signed(dir[i]) * $signed(cfg.nrm[i]);
            an_ff[i]    <= ($signed(cfg.anc[i]) - $signed(pos[i])) * $signed(cfg.nrm[i]);
            diff1_ff[i] <= 17'($signed(pos[i]) - $signed(cfg.anc[i]));
            dir1_ff[i]  <= dir[i];
         end
         f1_ff <= in_word.step_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         c28_ff   <= 34'(dn_ff[0]) + 34'(dn_ff[1]) + 34'(dn_ff[2]);
         n22_ff   <= 35'(an_ff[0]) + 35'(an_ff[1]) + 35'(an_ff[2]);
         diff2_ff <= diff1_ff;
         dir2_ff  <= dir1_ff;
         f2_ff    <= f1_ff;
      end
   end

   // reject non-positive or near parallel cosine and a plane behind the start
   always_comb begin
      fc      = f2_ff * c28_ff[31:0];
      ec_sum  = {1'b0, c28_ff[31:0]} + 33'd8192;
      rej3_in = c28_ff[33] || (c28_ff == 34'sd0) ||
                (c28_ff[32:0] < {4'b0, cfg.min_cos, 14'b0}) || n22_ff[34];
      if (ec_sum[32:14] > 19'd16384) begin
         ec3_in = 16'd16384;
      end else begin
         ec3_in = ec_sum[29:14];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         rej3_ff  <= rej3_in;
         lim3_ff  <= fc[47:14];
         n3_ff    <= n22_ff;
         c3_ff    <= c28_ff[31:0];
         ec3_ff   <= ec3_in;
         diff3_ff <= diff2_ff;
         dir3_ff  <= dir2_ff;
         f3_ff    <= f2_ff;
      end
   end

   // reject a plane beyond the free path, seed the divider
   assign rej4_in = rej3_ff || (n3_ff[33:0] > lim3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= v3_ff;
      end
      if (en) begin
         out_rem             <= {2'b0, n3_ff[33:2]};
         out_lo              <= n3_ff[1:0];
         out_c               <= c3_ff;
         out_side.reject     <= rej4_in;
         out_side.ec         <= ec3_ff;
         out_side.dir        <= dir3_ff;
         out_side.diff       <= diff3_ff;
         out_side.step_len   <= f3_ff;
      end
   end

endmodule

/* design/rssc_div.sv */
module rssc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [33:0]       in_rem,
   input  logic [1:0]        in_lo,
   input  logic [31:0]       in_c,
   input  rssc_pkg::side_type in_side,
   output logic              out_valid,
   output logic [15:0]       out_q,
   output rssc_pkg::side_type out_side
);
   import rssc_pkg::*;

   // one restoring step per stage, most significant quotient bit first
   logic                 valid_ff [DIV_STEPS];
   logic [33:0]          rem_ff   [DIV_STEPS];
   logic [15:0]          q_ff     [DIV_STEPS];
   logic [1:0]           lo_ff    [DIV_STEPS];
   logic [31:0]          c_ff     [DIV_STEPS];
   side_type             side_ff  [DIV_STEPS];

   logic                 src_valid [DIV_STEPS];
   logic [33:0]          src_rem   [DIV_STEPS];
   logic [15:0]          src_q     [DIV_STEPS];
   logic [1:0]           src_lo    [DIV_STEPS];
   logic [31:0]          src_c     [DIV_STEPS];
   side_type             src_side  [DIV_STEPS];
   logic [33:0]          rem_in    [DIV_STEPS];
   logic [15:0]          q_in      [DIV_STEPS];

   always_comb begin
      logic [33:0] sh;
      logic        nb;
      logic        ge;
      src_valid[0] = in_valid;
      src_rem[0]   = in_rem;
      src_q[0]     = '0;
      src_lo[0]    = in_lo;
      src_c[0]     = in_c;
      src_side[0]  = in_side;
      for (int k = 1; k < DIV_STEPS; k++) begin
         src_valid[k] = valid_ff[k-1];
         src_rem[k]   = rem_ff[k-1];
         src_q[k]     = q_ff[k-1];
         src_lo[k]    = lo_ff[k-1];
         src_c[k]     = c_ff[k-1];
         src_side[k]  = side_ff[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         // dividend bits below the seed: two low numerator bits, then zeros
         if (k == 0) begin
            nb = src_lo[k][1];
         end else if (k == 1) begin
            nb = src_lo[k][0];
         end else begin
            nb = 1'b0;
         end
         sh = {src_rem[k][32:0], nb};
         ge = (sh >= {2'b0, src_c[k]});
         rem_in[k] = ge ? sh - {2'b0, src_c[k]} : sh;
         q_in[k]   = {src_q[k][14:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid[k];
         end
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            lo_ff[k]   <= src_lo[k];
            c_ff[k]    <= src_c[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_q     = q_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

`ifndef NO_ASSERTIONS
   // a step that survived the range test never lands past its free path
   a_t_within_path: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_side.reject |-> out_q <= out_side.step_len)
      else $error("plane parameter exceeds free path");
`endif

endmodule

/* design/rssc_back.sv */
module rssc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [15:0]       in_t,
   input  rssc_pkg::side_type in_side,
   input  rssc_pkg::cfg_type cfg,
   output logic              out_valid,
   output rssc_pkg::rsp_word_type out_word
);
   import rssc_pkg::*;

   // stage 1: t times direction
   logic               v1_ff;
   logic signed [32:0] td_ff [3];
   logic [2:0][16:0]   diff1_ff;
   logic               rej1_ff;
   logic [15:0]        ec1_ff;

   // stage 2: rounded hit offset
   logic               v2_ff;
   logic signed [19:0] q_ff [3];
   logic               rej2_ff;
   logic [15:0]        ec2_ff;

   // stage 3: squares and edge projections
   logic               v3_ff;
   logic [39:0]        sq_ff [3];
   logic signed [35:0] pe1_ff [3];
   logic signed [35:0] pe2_ff [3];
   logic               rej3_ff;
   logic [15:0]        ec3_ff;

   logic signed [33:0] q22 [3];
   logic [41:0]        ssum;
   logic signed [37:0] p1;
   logic signed [37:0] p2;
   logic               outside;
   logic               hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            td_ff[i] <= $signed({1'b0, in_t}) * $signed(in_side.dir[i]);
         end
         diff1_ff <= in_side.diff;
         rej1_ff  <= in_side.reject;
         ec1_ff   <= in_side.ec;
      end
   end

   // offset from anchor in Q.22, round half up back to Q.8
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q22[i] = 34'($signed({diff1_ff[i], 14'b0})) + 34'(td_ff[i]) + 34'sd8192;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            q_ff[i] <= q22[i][33:14];
         end
         rej2_ff <= rej1_ff;
         ec2_ff  <= ec1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]  <= 40'(q_ff[i] * q_ff[i]);
            pe1_ff[i] <= q_ff[i] * $signed(cfg.e1[i]);
            pe2_ff[i] <= q_ff[i] * $signed(cfg.e2[i]);
         end
         rej3_ff <= rej2_ff;
         ec3_ff  <= ec2_ff;
      end
   end

   // inside test for the selected surface
   always_comb begin
      ssum = 42'(sq_ff[0]) + 42'(sq_ff[1]) + 42'(sq_ff[2]);
      p1   = 38'(pe1_ff[0]) + 38'(pe1_ff[1]) + 38'(pe1_ff[2]);
      p2   = 38'(pe2_ff[0]) + 38'(pe2_ff[1]) + 38'(pe2_ff[2]);
      if (cfg.kind) begin
         outside = p1[37] || (p1 > $signed({5'b0, cfg.len1})) ||
                   p2[37] || (p2 > $signed({5'b0, cfg.len2}));
      end else begin
         outside = ssum > {10'b0, cfg.rsq};
      end
      hit = !rej3_ff && !outside;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= v3_ff;
      end
      if (en) begin
         out_word.crosses      <= hit;
         out_word.entrance_cos <= hit ? ec3_ff : 16'd0;
      end
   end

endmodule
